// ----- sv/cfsr_pkg.sv -----
// ----------------------------------------------------------------------------
// cfsr_pkg
// Shared constants, status codes and the byte-wide CRC-32 step for the
// CRC-32 checked frame receiver.
// ----------------------------------------------------------------------------
package cfsr_pkg;

  localparam int HEADER_BYTES = 32;
  localparam int HDR_BITS     = HEADER_BYTES * 8;
  localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
  localparam int LEN_W        = 17;
  localparam int OUT_DATA_W   = 232;
  localparam int OUT_USER_W   = 4;

  localparam logic [LEN_W-1:0] MAX_LEN  = 17'd65536;
  localparam logic [31:0]      CRC_POLY = 32'hEDB88320;
  localparam logic [31:0]      CRC_INIT = 32'hFFFFFFFF;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MAGIC    = 3'd1;
  localparam logic [2:0] ST_VERSION  = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;

  localparam logic [1:0] REG_MAGIC    = 2'd0;
  localparam logic [1:0] REG_VERSION  = 2'd1;
  localparam logic [1:0] REG_MAX_LEN  = 2'd2;
  localparam logic [1:0] REG_CAPACITY = 2'd3;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/crc32_frame_stream_receiver_core.sv -----
// ----------------------------------------------------------------------------
// crc32_frame_stream_receiver_core
// Collects a 32-byte big-endian header from a byte stream, checks it, passes
// payload beats out with their offset and closes each frame with a verdict.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat content
// s_axis    in         one stream byte per beat
// m_axis    out        payload byte and/or frame verdict with header fields
// apb       in         register writes and reads, pready always high
//
// Each payload byte passes from the input register to the result register,
// and a new byte is accepted in every cycle while results are taken.
// A byte waits in the input register while a result is stalled at the output.
// Reset restores the register defaults and starts hunting for a header.
module crc32_frame_stream_receiver_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // in_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // payload_byte, payload_offset, request_code, peer_status, item_index,
  // transaction_id, payload_length, header_value, received_checksum
  output logic [cfsr_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                              m_tlast,   // frame_end
  output logic [cfsr_pkg::OUT_USER_W-1:0]   m_tuser,   // byte_valid, frame_status
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [31:0]                   magic_word;
  logic [15:0]                   protocol_version;
  logic [cfsr_pkg::LEN_W-1:0]    len_limit;
  logic [cfsr_pkg::LEN_W-1:0]    payload_capacity;
  logic [cfsr_pkg::LEN_W-1:0]    wr_len;

  logic                          in_valid;
  logic [7:0]                    in_byte;
  logic                          advance;

  logic [cfsr_pkg::HDR_BITS-1:0] hdr;
  logic [cfsr_pkg::HDR_BITS-1:0] hdr_next;
  logic [cfsr_pkg::HDR_BITS-1:0] hdr_sel;
  logic [cfsr_pkg::HDR_CNT_W-1:0] header_count;
  logic                          payload_phase;
  logic [cfsr_pkg::LEN_W-1:0]    payload_count;
  logic [cfsr_pkg::LEN_W-1:0]    payload_count_inc;
  logic [cfsr_pkg::LEN_W-1:0]    expected_length;
  logic [31:0]                   crc;
  logic [31:0]                   crc_upd;
  logic [7:0]                    crc_in;
  logic [31:0]                   hdr_len;

  logic                          res_produce;
  logic                          res_byte_valid;
  logic                          res_end;
  logic [2:0]                    res_status;
  logic                          frame_clear;
  logic                          enter_payload;
  logic                          crc_ok;

  assign pready   = 1'b1;
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Register port
  assign wr_len = (pwdata[16:0] > cfsr_pkg::MAX_LEN) ? cfsr_pkg::MAX_LEN : pwdata[16:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word       <= 32'd0;
      protocol_version <= 16'd0;
      len_limit        <= cfsr_pkg::MAX_LEN;
      payload_capacity <= cfsr_pkg::MAX_LEN;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        cfsr_pkg::REG_MAGIC:    magic_word       <= pwdata;
        cfsr_pkg::REG_VERSION:  protocol_version <= pwdata[15:0];
        cfsr_pkg::REG_MAX_LEN:  len_limit        <= wr_len;
        cfsr_pkg::REG_CAPACITY: payload_capacity <= wr_len;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      cfsr_pkg::REG_MAGIC:    prdata = magic_word;
      cfsr_pkg::REG_VERSION:  prdata = {16'd0, protocol_version};
      cfsr_pkg::REG_MAX_LEN:  prdata = {15'd0, len_limit};
      cfsr_pkg::REG_CAPACITY: prdata = {15'd0, payload_capacity};
      default:                prdata = 32'd0;
    endcase
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Frame logic
  assign hdr_next          = {hdr[cfsr_pkg::HDR_BITS-9:0], in_byte};
  assign hdr_sel           = payload_phase ? hdr : hdr_next;
  assign hdr_len           = hdr_sel[127:96];
  assign crc_in            = (!payload_phase && header_count[4:2] == 3'b101) ? 8'd0 : in_byte;
  assign crc_upd           = cfsr_pkg::crc_byte(crc, crc_in);
  assign crc_ok            = ((crc_upd ^ cfsr_pkg::CRC_INIT) == hdr_sel[95:64]);
  assign payload_count_inc = payload_count + 17'd1;

  always_comb begin
    res_produce    = 1'b0;
    res_byte_valid = 1'b0;
    res_end        = 1'b0;
    res_status     = cfsr_pkg::ST_OK;
    frame_clear    = 1'b0;
    enter_payload  = 1'b0;
    if (!payload_phase) begin
      if (header_count == 5'(cfsr_pkg::HEADER_BYTES - 1)) begin
        res_produce = 1'b1;
        res_end     = 1'b1;
        frame_clear = 1'b1;
        if (hdr_next[255:224] != magic_word) begin
          res_status = cfsr_pkg::ST_MAGIC;
        end else if (hdr_next[223:208] != protocol_version) begin
          res_status = cfsr_pkg::ST_VERSION;
        end else if (hdr_len > {15'd0, len_limit} || hdr_len > {15'd0, payload_capacity}) begin
          res_status = cfsr_pkg::ST_LENGTH;
        end else if (hdr_len == 32'd0) begin
          res_status = crc_ok ? cfsr_pkg::ST_OK : cfsr_pkg::ST_CHECKSUM;
        end else begin
          res_produce   = 1'b0;
          res_end       = 1'b0;
          frame_clear   = 1'b0;
          enter_payload = 1'b1;
        end
      end
    end else begin
      res_produce    = 1'b1;
      res_byte_valid = 1'b1;
      if (payload_count_inc >= expected_length) begin
        res_end     = 1'b1;
        frame_clear = 1'b1;
        res_status  = crc_ok ? cfsr_pkg::ST_OK : cfsr_pkg::ST_CHECKSUM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= '0;
      payload_phase   <= 1'b0;
      payload_count   <= '0;
      expected_length <= '0;
      crc             <= cfsr_pkg::CRC_INIT;
    end else if (advance) begin
      if (frame_clear) begin
        header_count    <= '0;
        payload_phase   <= 1'b0;
        payload_count   <= '0;
        expected_length <= '0;
        crc             <= cfsr_pkg::CRC_INIT;
      end else begin
        crc <= crc_upd;
        if (enter_payload) begin
          payload_phase   <= 1'b1;
          payload_count   <= '0;
          expected_length <= hdr_len[cfsr_pkg::LEN_W-1:0];
        end else if (payload_phase) begin
          payload_count <= payload_count_inc;
        end else begin
          header_count <= header_count + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !payload_phase) begin
      hdr <= hdr_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_produce;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_produce) begin
      m_tdata[7:0]     <= res_byte_valid ? in_byte : 8'd0;
      m_tdata[23:8]    <= res_byte_valid ? payload_count[15:0] : 16'd0;
      m_tdata[39:24]   <= hdr_sel[207:192];
      m_tdata[55:40]   <= hdr_sel[191:176];
      m_tdata[71:56]   <= hdr_sel[175:160];
      m_tdata[103:72]  <= hdr_sel[159:128];
      m_tdata[135:104] <= hdr_sel[127:96];
      m_tdata[199:136] <= hdr_sel[63:0];
      m_tdata[231:200] <= hdr_sel[95:64];
      m_tlast          <= res_end;
      m_tuser          <= {res_status, res_byte_valid};
    end
  end

endmodule

// ----- sv/cfsr_checker.sv -----
// ----------------------------------------------------------------------------
// cfsr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
module cfsr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [cfsr_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast,
  input logic [cfsr_pkg::OUT_USER_W-1:0] m_tuser
);

  // A stalled result beat must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // A beat without a payload byte always closes a frame.
  a_nobyte_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("beat without payload byte does not close a frame");

  // A beat without a payload byte carries a zero byte and offset.
  a_nobyte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == 24'd0)
    else $error("verdict beat carries payload data");

  // Only a frame-closing beat reports a status other than ok.
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[3:1] == cfsr_pkg::ST_OK)
    else $error("status reported mid-frame");

endmodule

bind crc32_frame_stream_receiver_core cfsr_checker u_cfsr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb - CRC-32 checked frame receiver testbench
// Sends byte streams of framed, corrupted and noisy data with random idling
// on both stream sides. A scoreboard tracks header collection, payload
// counting and the running CRC, and checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bit        byte_valid;
    bit [7:0]  payload_byte;
    bit [15:0] payload_offset;
    bit        frame_end;
    bit [2:0]  frame_status;
    bit [15:0] request_code;
    bit [15:0] peer_status;
    bit [15:0] item_index;
    bit [31:0] transaction_id;
    bit [31:0] payload_length;
    bit [63:0] header_value;
    bit [31:0] received_checksum;
  } result_t;

  typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

  class frame_scoreboard;
    bit [31:0]   magic;
    bit [15:0]   version;
    bit [16:0]   max_len;
    bit [16:0]   capacity;
    bit [7:0]    hdr [cfsr_pkg::HEADER_BYTES];
    int unsigned hdr_cnt;
    bit          pay_phase;
    int unsigned pay_cnt;
    int unsigned pay_len;
    bit [31:0]   crc;
    result_t     expected [$];
    int          errors;

    function new();
      magic = '0;
      version = '0;
      max_len = cfsr_pkg::MAX_LEN;
      capacity = cfsr_pkg::MAX_LEN;
      errors = 0;
      clear_frame();
    endfunction

    static function bit [31:0] crc_step(bit [31:0] c_in, bit [7:0] b);
      bit [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      end
      return c;
    endfunction

    function void clear_frame();
      foreach (hdr[k]) hdr[k] = '0;
      hdr_cnt = 0;
      pay_phase = 1'b0;
      pay_cnt = 0;
      pay_len = 0;
      crc = 32'hFFFFFFFF;
    endfunction

    function void write_reg(bit [1:0] idx, bit [31:0] v);
      bit [16:0] v17;
      v17 = v[16:0];
      if (v17 > cfsr_pkg::MAX_LEN) v17 = cfsr_pkg::MAX_LEN;
      case (idx)
        cfsr_pkg::REG_MAGIC:    magic = v;
        cfsr_pkg::REG_VERSION:  version = v[15:0];
        cfsr_pkg::REG_MAX_LEN:  max_len = v17;
        cfsr_pkg::REG_CAPACITY: capacity = v17;
        default: ;
      endcase
    endfunction

    function bit [63:0] be(int at, int n);
      bit [63:0] v;
      v = '0;
      for (int k = 0; k < n; k++) v = (v << 8) | {56'd0, hdr[at + k]};
      return v;
    endfunction

    function bit [2:0] verdict();
      bit [63:0] got;
      got = be(20, 4);
      return (~crc == got[31:0]) ? cfsr_pkg::ST_OK : cfsr_pkg::ST_CHECKSUM;
    endfunction

    function void fill_header(ref result_t r);
      r.request_code = 16'(be(6, 2));
      r.peer_status = 16'(be(8, 2));
      r.item_index = 16'(be(10, 2));
      r.transaction_id = 32'(be(12, 4));
      r.payload_length = 32'(be(16, 4));
      r.header_value = be(24, 8);
      r.received_checksum = 32'(be(20, 4));
    endfunction

    function void note_byte(bit [7:0] b);
      result_t r;
      int unsigned pos;
      bit [63:0] len;
      bit [2:0] st;
      r = '0;
      if (!pay_phase) begin
        pos = hdr_cnt % cfsr_pkg::HEADER_BYTES;
        hdr[pos] = b;
        crc = crc_step(crc, (pos >= 20 && pos < 24) ? 8'h00 : b);
        hdr_cnt = pos + 1;
        if (hdr_cnt < cfsr_pkg::HEADER_BYTES) return;
        len = be(16, 4);
        if (be(0, 4) != {32'd0, magic}) st = cfsr_pkg::ST_MAGIC;
        else if (be(4, 2) != {48'd0, version}) st = cfsr_pkg::ST_VERSION;
        else if (len > {47'd0, max_len} || len > {47'd0, capacity}) st = cfsr_pkg::ST_LENGTH;
        else if (len == 0) st = verdict();
        else begin
          pay_len = len[31:0];
          pay_cnt = 0;
          pay_phase = 1'b1;
          return;
        end
        fill_header(r);
        r.frame_end = 1'b1;
        r.frame_status = st;
        expected.push_back(r);
        clear_frame();
      end else begin
        crc = crc_step(crc, b);
        fill_header(r);
        r.byte_valid = 1'b1;
        r.payload_byte = b;
        r.payload_offset = pay_cnt[15:0];
        pay_cnt++;
        if (pay_cnt >= pay_len) begin
          r.frame_end = 1'b1;
          r.frame_status = verdict();
          clear_frame();
        end
        expected.push_back(r);
      end
    endfunction

    function void report(string msg);
      errors++;
      $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function void cmp(string name, bit [63:0] got, bit [63:0] want);
      if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected.size() == 0) begin
        report("result beat with no expected result");
        return;
      end
      want = expected.pop_front();
      cmp("byte_valid", 64'(got.byte_valid), 64'(want.byte_valid));
      cmp("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
      cmp("payload_offset", 64'(got.payload_offset), 64'(want.payload_offset));
      cmp("frame_end", 64'(got.frame_end), 64'(want.frame_end));
      cmp("frame_status", 64'(got.frame_status), 64'(want.frame_status));
      cmp("request_code", 64'(got.request_code), 64'(want.request_code));
      cmp("peer_status", 64'(got.peer_status), 64'(want.peer_status));
      cmp("item_index", 64'(got.item_index), 64'(want.item_index));
      cmp("transaction_id", 64'(got.transaction_id), 64'(want.transaction_id));
      cmp("payload_length", 64'(got.payload_length), 64'(want.payload_length));
      cmp("header_value", got.header_value, want.header_value);
      cmp("received_checksum", 64'(got.received_checksum), 64'(want.received_checksum));
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function bit aligned();
      return !pay_phase && hdr_cnt == 0;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [cfsr_pkg::OUT_DATA_W-1:0] m_tdata;
  logic        m_tlast;
  logic [cfsr_pkg::OUT_USER_W-1:0] m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_scoreboard sb = new();
  int  sent = 0;
  int  hold_cycles = 0;
  int  s_left = 0;
  int  m_left = 0;
  bit  s_calm = 1'b0;
  bit  m_calm = 1'b0;

  crc32_frame_stream_receiver_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int next_gap(ref int left, ref bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(20, 120);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic send_byte(input bit [7:0] b);
    int gap;
    gap = next_gap(s_left, s_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    sent++;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
      sb.expected.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input bit [1:0] idx, input bit [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic configure(input bit [31:0] magic, input bit [31:0] version,
                           input bit [31:0] max_len, input bit [31:0] capacity);
    settle();
    write_reg(cfsr_pkg::REG_MAGIC, magic);
    write_reg(cfsr_pkg::REG_VERSION, version);
    write_reg(cfsr_pkg::REG_MAX_LEN, max_len);
    write_reg(cfsr_pkg::REG_CAPACITY, capacity);
  endtask

  task automatic send_frame(input bit [31:0] magic, input bit [15:0] version,
                            input bit [31:0] len_field, input int pay_n,
                            input bit corrupt, input fill_e fill);
    bit [7:0]   fb [cfsr_pkg::HEADER_BYTES];
    bit [7:0]   pay [$];
    bit [255:0] h;
    bit [15:0]  req, sts, idx;
    bit [31:0]  tid, c;
    bit [63:0]  val;
    case (fill)
      FILL_ZERO: {req, sts, idx, tid, val} = '0;
      FILL_ONES: {req, sts, idx, tid, val} = '1;
      default: begin
        req = 16'($urandom);
        sts = 16'($urandom);
        idx = 16'($urandom);
        tid = $urandom;
        val = {$urandom, $urandom};
      end
    endcase
    h = {magic, version, req, sts, idx, tid, len_field, 32'h0, val};
    for (int k = 0; k < cfsr_pkg::HEADER_BYTES; k++) fb[k] = h[255 - 8 * k -: 8];
    for (int k = 0; k < pay_n; k++) begin
      case (fill)
        FILL_ZERO: pay.push_back(8'h00);
        FILL_ONES: pay.push_back(8'hFF);
        default:   pay.push_back(8'($urandom));
      endcase
    end
    c = 32'hFFFFFFFF;
    foreach (fb[k]) c = frame_scoreboard::crc_step(c, fb[k]);
    foreach (pay[k]) c = frame_scoreboard::crc_step(c, pay[k]);
    c = ~c;
    if (corrupt) c ^= 32'h1 << $urandom_range(0, 31);
    {fb[20], fb[21], fb[22], fb[23]} = c;
    foreach (fb[k]) send_byte(fb[k]);
    foreach (pay[k]) send_byte(pay[k]);
  endtask

  task automatic resync();
    while (!sb.aligned()) send_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic int unsigned good_len(int unsigned lim);
    if (lim == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, lim < 300 ? lim : 300);
    return $urandom_range(0, lim < 24 ? lim : 24);
  endfunction

  function automatic bit [31:0] pick_limit();
    case ($urandom_range(0, 4))
      0:       return 0;
      1, 2:    return $urandom_range(1, 40);
      3:       return 32'(cfsr_pkg::MAX_LEN);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_frame();
    int unsigned lim, n;
    int kind;
    resync();
    lim = (sb.max_len < sb.capacity) ? sb.max_len : sb.capacity;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 13) begin
      send_frame(sb.magic ^ (32'h1 << $urandom_range(0, 31)), sb.version, good_len(lim),
                 0, 1'b0, FILL_RAND);
    end else if (kind < 18) begin
      send_frame(sb.magic, sb.version ^ (16'h1 << $urandom_range(0, 15)), good_len(lim),
                 0, 1'b0, FILL_RAND);
    end else if (kind < 23) begin
      n = $urandom_range(0, 1) ? lim + 1 + $urandom_range(0, 3) : {1'b1, 31'($urandom)};
      send_frame(sb.magic, sb.version, n, 0, 1'b0, FILL_RAND);
    end else begin
      n = good_len(lim);
      send_frame(sb.magic, sb.version, n, n, kind < 33,
                 kind > 96 ? FILL_ONES : (kind > 94 ? FILL_ZERO : FILL_RAND));
    end
  endtask

  initial begin
    int target;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(32'h0, 16'h0, 0, 0, 1'b0, FILL_ZERO);
    send_frame(32'h0, 16'h0, 0, 0, 1'b1, FILL_ONES);
    send_frame(32'h0, 16'h0, 2, 2, 1'b0, FILL_RAND);

    configure(32'hFFFFFFFF, 32'h0000FFFF, 32'h0001FFFF, 32'hFFFFFFFF);
    send_frame(32'hFFFFFFFF, 16'hFFFF, 1, 1, 1'b0, FILL_ONES);
    send_frame(32'h7FFFFFFF, 16'hFFFF, 0, 0, 1'b0, FILL_RAND);
    send_frame(32'hFFFFFFFE, 16'h0000, 32'hFFFFFFFF, 0, 1'b0, FILL_RAND);
    send_frame(32'hFFFFFFFF, 16'hFFFE, 32'hFFFFFFFF, 0, 1'b0, FILL_RAND);
    send_frame(32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 0, 1'b0, FILL_ONES);
    send_frame(32'hFFFFFFFF, 16'hFFFF, 65537, 0, 1'b0, FILL_ZERO);
    send_frame(32'hFFFFFFFF, 16'hFFFF, 3, 3, 1'b1, FILL_RAND);
    repeat (5) send_byte(8'($urandom_range(0, 255)));
    resync();

    configure(32'hA5A5C3C3, 32'h1234, 10, 5);
    send_frame(32'hA5A5C3C3, 16'h1234, 6, 0, 1'b0, FILL_RAND);
    send_frame(32'hA5A5C3C3, 16'h1234, 5, 5, 1'b0, FILL_RAND);
    send_frame(32'hA5A5C3C3, 16'h1234, 11, 0, 1'b0, FILL_RAND);

    configure(32'hA5A5C3C3, 32'h1234, 32'h00020005, 10);
    send_frame(32'hA5A5C3C3, 16'h1234, 6, 0, 1'b0, FILL_RAND);
    send_frame(32'hA5A5C3C3, 16'h1234, 5, 5, 1'b0, FILL_RAND);

    configure(32'h00000001, 32'h0, 0, 0);
    send_frame(32'h00000001, 16'h0, 0, 0, 1'b0, FILL_RAND);
    send_frame(32'h00000001, 16'h0, 1, 0, 1'b0, FILL_RAND);

    configure(32'h80000000, 32'h8000, 32'(cfsr_pkg::MAX_LEN), 32'd65535);
    send_frame(32'h80000000, 16'h8000, 65536, 0, 1'b0, FILL_RAND);
    send_frame(32'h80000000, 16'h8000, 300, 300, 1'b0, FILL_RAND);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        configure($urandom, $urandom, 32'(cfsr_pkg::MAX_LEN), 32'(cfsr_pkg::MAX_LEN));
      end else if (ph == 2) begin
        configure(32'h0, 32'h0, pick_limit(), pick_limit());
      end else begin
        configure($urandom, $urandom, pick_limit(), pick_limit());
      end
      if (ph == 0) hold_cycles = 300;
      target = sent + 150;
      while (sent < target) random_frame();
    end

    settle();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int gap;
    result_t got;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = next_gap(m_left, m_calm);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.payload_byte = m_tdata[7:0];
      got.payload_offset = m_tdata[23:8];
      got.request_code = m_tdata[39:24];
      got.peer_status = m_tdata[55:40];
      got.item_index = m_tdata[71:56];
      got.transaction_id = m_tdata[103:72];
      got.payload_length = m_tdata[135:104];
      got.header_value = m_tdata[199:136];
      got.received_checksum = m_tdata[231:200];
      got.frame_end = m_tlast;
      got.byte_valid = m_tuser[0];
      got.frame_status = m_tuser[3:1];
      sb.check_result(got);
    end
  end

  initial begin
    #(2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/cfsr_pkg.sv
sv/crc32_frame_stream_receiver_core.sv
sv/cfsr_checker.sv
sim/tb.sv
